>>> rtl/core/pcm_float_sample_converter_macros.svh
// Assertion macros shared by the converter RTL.
`ifndef PCM_FLOAT_SAMPLE_CONVERTER_MACROS_SVH
`define PCM_FLOAT_SAMPLE_CONVERTER_MACROS_SVH

// The consequent is checked in the same cycle as the antecedent.
`define PFSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfsc assertion failed");

// The consequent is checked in the cycle after the antecedent.
`define PFSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfsc assertion failed");

`endif

>>> rtl/core/pfsc_pkg.sv
// Shared types, sample kind codes and helper functions for the converter.
`default_nettype none
package pfsc_pkg;

    localparam logic [2:0] KIND_I8  = 3'd0;
    localparam logic [2:0] KIND_I16 = 3'd1;
    localparam logic [2:0] KIND_I24 = 3'd2;
    localparam logic [2:0] KIND_I32 = 3'd3;
    localparam logic [2:0] KIND_F32 = 3'd4;
    localparam logic [2:0] KIND_F64 = 3'd5;

    localparam logic CMD_DECODE = 1'b0;
    localparam logic CMD_ENCODE = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [63:0] sample_in;
    } t_req;

    typedef struct packed {
        logic [63:0] sample_out;
        logic        saturated;
    } t_rsp;

    // Index of the highest set bit; zero when no bit is set.
    function automatic logic [4:0] msb_index32(input logic [31:0] v);
        logic [4:0] idx;
        idx = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    // Number of bits below the sign bit for each PCM kind.
    function automatic logic [4:0] pcm_frac_bits(input logic [2:0] kind);
        logic [4:0] n;
        unique case (kind)
            KIND_I8:  n = 5'd7;
            KIND_I16: n = 5'd15;
            KIND_I24: n = 5'd23;
            default:  n = 5'd31;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/pcm_float_sample_converter.sv
// Top level of the PCM and float32 sample converter with its register port.
//
// Channel   Direction  Handshake             Payload
// request   in         start, busy           i_req (cmd, sample_in)
// result    out        o_done strobe         o_rsp (sample_out, saturated)
// config    in         psel, penable, pwrite sample_kind at byte address 0
//
// One request is taken in every cycle; busy is never raised.
// A result appears for one cycle once its request has passed the input register,
// one pass of decode or encode logic and the result register.
// Synchronous active-low reset clears the valid flags and sets the kind to int16.
// The receiver cannot stall, so nothing is ever held back.
`default_nettype none
`include "pcm_float_sample_converter_macros.svh"
module pcm_float_sample_converter (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire pfsc_pkg::t_req i_req,
    output logic               o_done,
    output pfsc_pkg::t_rsp     o_rsp,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import pfsc_pkg::*;

    logic [2:0]  r_kind;
    logic        r_in_valid;
    t_req        r_in;
    logic        r_out_valid;
    t_rsp        r_out;
    t_rsp        n_out;
    logic [63:0] dec_out;
    logic [63:0] enc_out;
    logic        enc_sat;

    assign busy = 1'b0;
    assign pready = 1'b1;
    assign prdata = {29'd0, r_kind};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_I16;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_kind <= pwdata[2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in <= i_req;
        r_out <= n_out;
    end

    pfsc_decode u_decode (
        .i_kind   (r_kind),
        .i_sample (r_in.sample_in),
        .o_sample (dec_out)
    );

    pfsc_encode u_encode (
        .i_kind      (r_kind),
        .i_float     (r_in.sample_in[31:0]),
        .o_sample    (enc_out),
        .o_saturated (enc_sat)
    );

    always_comb begin
        if (r_in.cmd == CMD_ENCODE) begin
            n_out.sample_out = enc_out;
            n_out.saturated = enc_sat;
        end else begin
            n_out.sample_out = dec_out;
            n_out.saturated = 1'b0;
        end
    end

    assign o_done = r_out_valid;
    assign o_rsp = r_out;

    `PFSC_ASSERT_SAME(a_req_gives_result, i_clk, i_rst_n, start && !busy, ##2 o_done)
    `PFSC_ASSERT_NEXT(a_no_req_no_stage, i_clk, i_rst_n, !(start && !busy), !r_in_valid)
    `PFSC_ASSERT_SAME(a_sat_only_encode, i_clk, i_rst_n, o_done && o_rsp.saturated, $past(i_req.cmd, 2) == CMD_ENCODE)
    `PFSC_ASSERT_SAME(a_f32_decode_pass, i_clk, i_rst_n, o_done && $past(i_req.cmd, 2) == CMD_DECODE && r_kind == KIND_F32, o_rsp.sample_out == {32'd0, $past(i_req.sample_in[31:0], 2)})

endmodule
`default_nettype wire

>>> rtl/core/pfsc_decode.sv
// Decode path: stored PCM or float samples to float32 bits.
`default_nettype none
module pfsc_decode (
    input  wire logic [2:0]  i_kind,
    input  wire logic [63:0] i_sample,
    output logic [63:0]      o_sample
);
    import pfsc_pkg::*;

    logic [31:0]  s_int;
    logic [31:0]  mag;
    logic [4:0]   p;
    logic [4:0]   nm1;
    logic [63:0]  ext;
    logic [31:0]  kept;
    logic         i_g;
    logic         i_st;
    logic         i_up;
    logic [7:0]   i_exp;
    logic [30:0]  i_body;
    logic [31:0]  int_res;

    logic         sg;
    logic [10:0]  e64;
    logic [51:0]  m64;
    logic [11:0]  fe;
    logic [10:0]  sh;
    logic [127:0] t;
    logic [30:0]  n_body;
    logic         n_up;
    logic [31:0]  f64_res;

    always_comb begin
        unique case (i_kind)
            KIND_I8:  s_int = {{24{i_sample[7]}}, i_sample[7:0]};
            KIND_I16: s_int = {{16{i_sample[15]}}, i_sample[15:0]};
            KIND_I24: s_int = {{8{i_sample[23]}}, i_sample[23:0]};
            default:  s_int = i_sample[31:0];
        endcase
        mag = s_int[31] ? (32'd0 - s_int) : s_int;
        p = msb_index32(mag);
        nm1 = pcm_frac_bits(i_kind);
        ext = {mag, 32'd0} >> p;
        ext = ext << 23;
        if (p <= 5'd23) begin
            kept = mag << (5'd23 - p);
            i_g = 1'b0;
            i_st = 1'b0;
        end else begin
            ext = {mag, 32'd0} >> (p - 5'd23);
            kept = ext[63:32];
            i_g = ext[31];
            i_st = |ext[30:0];
        end
        i_up = i_g & (i_st | kept[0]);
        i_exp = 8'(8'd127 + {3'd0, p} - {3'd0, nm1});
        i_body = {i_exp, kept[22:0]} + {30'd0, i_up};
        int_res = (mag == 32'd0) ? 32'd0 : {s_int[31], i_body};
    end

    always_comb begin
        sg = i_sample[63];
        e64 = i_sample[62:52];
        m64 = i_sample[51:0];
        fe = {1'b0, e64} - 12'd896;
        sh = 11'd926 - e64;
        t = '0;
        n_body = '0;
        n_up = 1'b0;
        if (e64 == 11'h7FF) begin
            if (m64 != 52'd0) begin
                f64_res = {sg, 9'h1FF, m64[50:29]};
            end else begin
                f64_res = {sg, 8'hFF, 23'd0};
            end
        end else if (e64 == 11'd0) begin
            f64_res = {sg, 31'd0};
        end else if (!fe[11] && fe >= 12'd255) begin
            f64_res = {sg, 8'hFF, 23'd0};
        end else if (!fe[11] && fe != 12'd0) begin
            n_up = m64[28] & ((|m64[27:0]) | m64[29]);
            n_body = {fe[7:0], m64[51:29]} + {30'd0, n_up};
            f64_res = {sg, n_body};
        end else if (sh > 11'd63) begin
            f64_res = {sg, 31'd0};
        end else begin
            t = {11'd0, 1'b1, m64, 64'd0} >> sh[5:0];
            n_up = t[63] & ((|t[62:0]) | t[64]);
            n_body = t[94:64] + {30'd0, n_up};
            f64_res = {sg, n_body};
        end
    end

    always_comb begin
        unique case (i_kind)
            KIND_I8, KIND_I16, KIND_I24, KIND_I32: o_sample = {32'd0, int_res};
            KIND_F32: o_sample = {32'd0, i_sample[31:0]};
            KIND_F64: o_sample = {32'd0, f64_res};
            default:  o_sample = 64'd0;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/pfsc_encode.sv
// Encode path: float32 bits to stored PCM with saturation, or to float kinds.
`default_nettype none
module pfsc_encode (
    input  wire logic [2:0]  i_kind,
    input  wire logic [31:0] i_float,
    output logic [63:0]      o_sample,
    output logic             o_saturated
);
    import pfsc_pkg::*;

    logic         sg;
    logic [7:0]   e;
    logic [22:0]  m;
    logic [4:0]   nm1;
    logic [9:0]   k;
    logic [53:0]  pfx;
    logic [30:0]  intp;
    logic         half;
    logic         fnz;
    logic [31:0]  hi;
    logic [31:0]  lo_pat;
    logic [31:0]  mask;
    logic [31:0]  magr;
    logic [31:0]  val;
    logic         big;
    logic         is_nan;
    logic [31:0]  pcm;
    logic         pcm_sat;
    logic [4:0]   p;
    logic [10:0]  w_exp;
    logic [52:0]  w_man;
    logic [63:0]  wide;

    always_comb begin
        sg = i_float[31];
        e = i_float[30:23];
        m = i_float[22:0];
        is_nan = (e == 8'hFF) && (m != 23'd0);
        nm1 = pcm_frac_bits(i_kind);
        k = {2'd0, e} - 10'd127 + {5'd0, nm1};
        big = !k[9] && (k >= {5'd0, nm1});
        pfx = '0;
        intp = '0;
        half = 1'b0;
        fnz = 1'b1;
        if (!k[9]) begin
            pfx = {30'd0, 1'b1, m} << k[4:0];
            intp = pfx[53:23];
            half = pfx[22];
            fnz = |pfx[22:0];
        end else if (k == 10'h3FF) begin
            half = 1'b1;
        end
        hi = (32'd1 << nm1) - 32'd1;
        lo_pat = 32'd1 << nm1;
        mask = hi | lo_pat;
        magr = {1'b0, intp} + {31'd0, half};
        val = sg ? (32'd0 - magr) : magr;
        pcm = val & mask;
        pcm_sat = 1'b0;
        if (is_nan) begin
            pcm = 32'd0;
        end else if (sg) begin
            if (big) begin
                pcm = lo_pat;
                pcm_sat = !((k == {5'd0, nm1}) && (m == 23'd0));
            end
        end else if (big || (({1'b0, intp} == hi) && fnz)) begin
            pcm = hi;
            pcm_sat = 1'b1;
        end
    end

    always_comb begin
        p = msb_index32({9'd0, m});
        w_exp = '0;
        w_man = '0;
        if (e == 8'hFF) begin
            wide = is_nan ? {sg, 11'h7FF, 1'b1, m[21:0], 29'd0} : {sg, 11'h7FF, 52'd0};
        end else if (e == 8'd0) begin
            if (m == 23'd0) begin
                wide = {sg, 63'd0};
            end else begin
                w_exp = 11'd874 + {6'd0, p};
                w_man = {30'd0, m} << (6'd52 - {1'b0, p});
                wide = {sg, w_exp, w_man[51:0]};
            end
        end else begin
            w_exp = {3'd0, e} + 11'd896;
            wide = {sg, w_exp, m, 29'd0};
        end
    end

    always_comb begin
        o_saturated = 1'b0;
        unique case (i_kind)
            KIND_I8, KIND_I16, KIND_I24, KIND_I32: begin
                o_sample = {32'd0, pcm};
                o_saturated = pcm_sat;
            end
            KIND_F32: o_sample = {32'd0, i_float};
            KIND_F64: o_sample = wide;
            default:  o_sample = 64'd0;
        endcase
    end

endmodule
`default_nettype wire
